@@ hw/rtl/spd_pkg.sv @@
// shared types and constants for the sensor packet deframer
package spd_pkg;

    localparam int unsigned CfgAddrWidth = 5;
    localparam int unsigned CfgIdxWidth  = 3;

    localparam logic [CfgIdxWidth-1:0] REG_START    = 3'd0;
    localparam logic [CfgIdxWidth-1:0] REG_VERSION  = 3'd1;
    localparam logic [CfgIdxWidth-1:0] REG_END      = 3'd2;
    localparam logic [CfgIdxWidth-1:0] REG_MARKER_A = 3'd3;
    localparam logic [CfgIdxWidth-1:0] REG_MARKER_B = 3'd4;

    localparam logic [7:0] RESET_START    = 8'd170;
    localparam logic [7:0] RESET_VERSION  = 8'd2;
    localparam logic [7:0] RESET_END      = 8'd85;
    localparam logic [7:0] RESET_MARKER_A = 8'd170;
    localparam logic [7:0] RESET_MARKER_B = 8'd85;

    localparam logic [1:0] EV_RECORD = 2'd0;
    localparam logic [1:0] EV_OK     = 2'd1;
    localparam logic [1:0] EV_ERROR  = 2'd2;

    localparam logic [1:0] LAST_VALUE_BYTE = 2'd3;

    typedef struct packed {
        logic [7:0] start_byte;
        logic [7:0] version_byte;
        logic [7:0] end_byte;
        logic [7:0] marker_a;
        logic [7:0] marker_b;
    } cfg_t;

    typedef enum logic [8:0] {
        PH_IDLE     = 9'b000000001,
        PH_VERSION  = 9'b000000010,
        PH_COUNT    = 9'b000000100,
        PH_ID_HIGH  = 9'b000001000,
        PH_ID_LOW   = 9'b000010000,
        PH_VALUE    = 9'b000100000,
        PH_CRC_LOW  = 9'b001000000,
        PH_CRC_HIGH = 9'b010000000,
        PH_END      = 9'b100000000
    } phase_t;

endpackage

@@ hw/rtl/sensor_packet_deframer_core.sv @@
// top level of the sensor packet deframer: byte framer with registered event output
// an event shows on the output register in the cycle after the byte that completes it is accepted
// throughput: one byte per cycle while in_ready is high, as the phase advances on every accepted byte
// in_ready stays high while the output register is empty or being taken
// reset: asynchronous active-low rst_n, phase back to hunting, totals zero
// reset also restores the configuration registers to their default bytes
module sensor_packet_deframer_core #(
    parameter int unsigned MAX_SENSORS = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [spd_pkg::CfgAddrWidth-1:0]  paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [7:0]                        rx_byte,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [1:0]                        event_kind,
    output logic [4:0]                        slot_index,
    output logic [15:0]                       sensor_id,
    output logic [31:0]                       value_bits,
    output logic                              accepted,
    output logic [5:0]                        packet_count,
    output logic [31:0]                       packets_ok,
    output logic [31:0]                       packets_error
);

    localparam logic [7:0] MaxCount = 8'(MAX_SENSORS);

    spd_pkg::cfg_t   cfg;
    logic            in_fire;

    spd_pkg::phase_t phase_reg, phase_next;
    logic [5:0]      expected_reg, expected_next;
    logic [5:0]      record_index_reg, record_index_next;
    logic [1:0]      value_idx_reg, value_idx_next;
    logic [7:0]      id_high_reg, id_high_next;
    logic [15:0]     current_id_reg, current_id_next;
    logic [23:0]     held_reg, held_next;
    logic [31:0]     good_reg, good_next;
    logic [31:0]     bad_reg, bad_next;

    logic            emit;
    logic [1:0]      kind;
    logic [4:0]      slot;
    logic [15:0]     id_out;
    logic [31:0]     bits_out;
    logic            acc_out;
    logic [5:0]      count_out;
    logic [5:0]      rec_inc;
    logic            hi_marker, lo_marker;

    logic            out_valid_reg;
    logic [1:0]      event_kind_reg;
    logic [4:0]      slot_index_reg;
    logic [15:0]     sensor_id_reg;
    logic [31:0]     value_bits_reg;
    logic            accepted_reg;
    logic [5:0]      packet_count_reg;

    spd_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;
    assign rec_inc  = record_index_reg + 6'd1;

    assign hi_marker = (current_id_reg[15:8] == cfg.marker_a) ||
                       (current_id_reg[15:8] == cfg.marker_b);
    assign lo_marker = (current_id_reg[7:0] == cfg.marker_a) ||
                       (current_id_reg[7:0] == cfg.marker_b);

    always_comb
    begin
        phase_next        = phase_reg;
        expected_next     = expected_reg;
        record_index_next = record_index_reg;
        value_idx_next    = value_idx_reg;
        id_high_next      = id_high_reg;
        current_id_next   = current_id_reg;
        held_next         = held_reg;
        good_next         = good_reg;
        bad_next          = bad_reg;
        emit              = 1'b0;
        kind              = spd_pkg::EV_RECORD;
        slot              = 5'd0;
        id_out            = 16'd0;
        bits_out          = 32'd0;
        acc_out           = 1'b0;
        count_out         = 6'd0;

        unique case (phase_reg)
            spd_pkg::PH_VERSION:
            begin
                if (rx_byte == cfg.version_byte)
                begin
                    phase_next = spd_pkg::PH_COUNT;
                end
                else
                begin
                    phase_next = spd_pkg::PH_IDLE;
                    bad_next   = bad_reg + 32'd1;
                    emit       = 1'b1;
                    kind       = spd_pkg::EV_ERROR;
                end
            end
            spd_pkg::PH_COUNT:
            begin
                expected_next     = rx_byte[5:0];
                record_index_next = 6'd0;
                value_idx_next    = 2'd0;
                if ((rx_byte != 8'd0) && (rx_byte <= MaxCount))
                begin
                    phase_next = spd_pkg::PH_ID_HIGH;
                end
                else
                begin
                    phase_next = spd_pkg::PH_IDLE;
                    bad_next   = bad_reg + 32'd1;
                    emit       = 1'b1;
                    kind       = spd_pkg::EV_ERROR;
                end
            end
            spd_pkg::PH_ID_HIGH:
            begin
                id_high_next = rx_byte;
                phase_next   = spd_pkg::PH_ID_LOW;
            end
            spd_pkg::PH_ID_LOW:
            begin
                current_id_next = {id_high_reg, rx_byte};
                value_idx_next  = 2'd0;
                held_next       = 24'd0;
                phase_next      = spd_pkg::PH_VALUE;
            end
            spd_pkg::PH_VALUE:
            begin
                if (value_idx_reg != spd_pkg::LAST_VALUE_BYTE)
                begin
                    unique case (value_idx_reg)
                        2'd0:    held_next[7:0]   = rx_byte;
                        2'd1:    held_next[15:8]  = rx_byte;
                        default: held_next[23:16] = rx_byte;
                    endcase
                    value_idx_next = value_idx_reg + 2'd1;
                end
                else
                begin
                    emit              = 1'b1;
                    kind              = spd_pkg::EV_RECORD;
                    slot              = record_index_reg[4:0];
                    id_out            = current_id_reg;
                    bits_out          = {rx_byte, held_reg};
                    acc_out           = !(hi_marker || lo_marker);
                    record_index_next = rec_inc;
                    value_idx_next    = 2'd0;
                    held_next         = 24'd0;
                    phase_next        = (rec_inc >= expected_reg) ? spd_pkg::PH_CRC_LOW
                                                                  : spd_pkg::PH_ID_HIGH;
                end
            end
            spd_pkg::PH_CRC_LOW:
            begin
                phase_next = spd_pkg::PH_CRC_HIGH;
            end
            spd_pkg::PH_CRC_HIGH:
            begin
                phase_next = spd_pkg::PH_END;
            end
            spd_pkg::PH_END:
            begin
                phase_next = spd_pkg::PH_IDLE;
                emit       = 1'b1;
                if (rx_byte == cfg.end_byte)
                begin
                    good_next = good_reg + 32'd1;
                    kind      = spd_pkg::EV_OK;
                    count_out = record_index_reg;
                end
                else
                begin
                    bad_next = bad_reg + 32'd1;
                    kind     = spd_pkg::EV_ERROR;
                end
            end
            default:
            begin
                // idle, and any stray phase code, hunts for start
                phase_next = (rx_byte == cfg.start_byte) ? spd_pkg::PH_VERSION
                                                         : spd_pkg::PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= spd_pkg::PH_IDLE;
            expected_reg     <= 6'd0;
            record_index_reg <= 6'd0;
            value_idx_reg    <= 2'd0;
            id_high_reg      <= 8'd0;
            current_id_reg   <= 16'd0;
            held_reg         <= 24'd0;
            good_reg         <= 32'd0;
            bad_reg          <= 32'd0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                phase_reg        <= phase_next;
                expected_reg     <= expected_next;
                record_index_reg <= record_index_next;
                value_idx_reg    <= value_idx_next;
                id_high_reg      <= id_high_next;
                current_id_reg   <= current_id_next;
                held_reg         <= held_next;
                good_reg         <= good_next;
                bad_reg          <= bad_next;
            end
            if (in_fire && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, loaded with each new event
    always_ff @(posedge clk)
    begin
        if (in_fire && emit)
        begin
            event_kind_reg   <= kind;
            slot_index_reg   <= slot;
            sensor_id_reg    <= id_out;
            value_bits_reg   <= bits_out;
            accepted_reg     <= acc_out;
            packet_count_reg <= count_out;
        end
    end

    assign out_valid     = out_valid_reg;
    assign event_kind    = event_kind_reg;
    assign slot_index    = slot_index_reg;
    assign sensor_id     = sensor_id_reg;
    assign value_bits    = value_bits_reg;
    assign accepted      = accepted_reg;
    assign packet_count  = packet_count_reg;
    assign packets_ok    = good_reg;
    assign packets_error = bad_reg;

    a_phase_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(phase_reg))
        else $error("phase register lost its one-hot code");

    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (event_kind_reg == spd_pkg::EV_RECORD) ||
                          (event_kind_reg == spd_pkg::EV_OK) ||
                          (event_kind_reg == spd_pkg::EV_ERROR))
        else $error("illegal event kind on output");

    a_ok_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (event_kind_reg == spd_pkg::EV_OK)) |->
            ((packet_count_reg != 6'd0) && (8'(packet_count_reg) <= MaxCount)))
        else $error("packet ok with a record count out of range");

    a_packet_fields_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (event_kind_reg != spd_pkg::EV_RECORD)) |->
            ((sensor_id_reg == 16'd0) && (value_bits_reg == 32'd0) &&
             !accepted_reg && (slot_index_reg == 5'd0)))
        else $error("record fields set on a packet event");

    a_good_end: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (phase_reg == spd_pkg::PH_END) && (rx_byte == cfg.end_byte)) |=>
            (out_valid_reg && (event_kind_reg == spd_pkg::EV_OK) &&
             (good_reg == $past(good_reg) + 32'd1)))
        else $error("good end byte did not report packet ok");

endmodule

@@ hw/rtl/spd_cfg_regs.sv @@
// apb configuration registers of the sensor packet deframer
module spd_cfg_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [spd_pkg::CfgAddrWidth-1:0]  paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    output spd_pkg::cfg_t                     cfg
);

    spd_pkg::cfg_t                    cfg_reg;
    logic                             wr_en;
    logic [spd_pkg::CfgIdxWidth-1:0]  idx;

    assign pready = 1'b1;
    assign idx    = paddr[spd_pkg::CfgAddrWidth-1:2];
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_byte   <= spd_pkg::RESET_START;
            cfg_reg.version_byte <= spd_pkg::RESET_VERSION;
            cfg_reg.end_byte     <= spd_pkg::RESET_END;
            cfg_reg.marker_a     <= spd_pkg::RESET_MARKER_A;
            cfg_reg.marker_b     <= spd_pkg::RESET_MARKER_B;
        end
        else if (wr_en)
        begin
            unique case (idx)
                spd_pkg::REG_START:    cfg_reg.start_byte   <= pwdata[7:0];
                spd_pkg::REG_VERSION:  cfg_reg.version_byte <= pwdata[7:0];
                spd_pkg::REG_END:      cfg_reg.end_byte     <= pwdata[7:0];
                spd_pkg::REG_MARKER_A: cfg_reg.marker_a     <= pwdata[7:0];
                spd_pkg::REG_MARKER_B: cfg_reg.marker_b     <= pwdata[7:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            spd_pkg::REG_START:    prdata = {24'd0, cfg_reg.start_byte};
            spd_pkg::REG_VERSION:  prdata = {24'd0, cfg_reg.version_byte};
            spd_pkg::REG_END:      prdata = {24'd0, cfg_reg.end_byte};
            spd_pkg::REG_MARKER_A: prdata = {24'd0, cfg_reg.marker_a};
            spd_pkg::REG_MARKER_B: prdata = {24'd0, cfg_reg.marker_b};
            default:               prdata = 32'd0;
        endcase
    end

endmodule
